/* hdl/pspl_pkg.sv */
// ----------------------------------------------------------------------------
// PAT section PMT PID lookup: shared definitions
// Widths, section layout constants, status codes and the result bundle
// passed from the section scanner to the result register.
// ----------------------------------------------------------------------------
package pspl_pkg;

   // Largest section the block accepts as well formed.
   localparam int unsigned MAX_SECTION_BYTES = 4096;

   // Field widths.
   localparam int unsigned COUNT_W   = 13;
   localparam int unsigned LENGTH_W  = 12;
   localparam int unsigned PID_W     = 13;
   localparam int unsigned SERVICE_W = 16;
   localparam int unsigned ENTRY_W   = 24;

   // Section layout.
   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned CRC_BYTES    = 4;
   localparam int unsigned LEN_OVERHEAD = 3;

   // Byte positions of the section length field.
   localparam logic [COUNT_W-1:0] POS_LENGTH_HI = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] POS_LENGTH_LO = COUNT_W'(2);

   // Entry phase of the byte that completes an entry.
   localparam logic [1:0] PHASE_LAST = 2'd3;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_MISMATCH  = 2'd2
   } status_type;

   typedef struct packed {
      status_type       status;
      logic [PID_W-1:0] pmt_pid;
   } result_type;

endpackage

/* hdl/pspl_in_reg.sv */
// ----------------------------------------------------------------------------
// PAT section PMT PID lookup: input register
// Holds one accepted section byte until the scanner consumes it.
// ----------------------------------------------------------------------------
module pspl_in_reg import pspl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_section_byte,
   input  logic       req_last_byte,
   input  logic       consume,
   output logic       item_valid,
   output logic [7:0] item_byte,
   output logic       item_last
);

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;

   // The register takes a new item when empty or when its item leaves now.
   assign req_ready = !valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         valid_ff <= 1'b1;
      end else if (consume) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_section_byte;
         last_ff <= req_last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;
   assign item_last  = last_ff;

endmodule

/* hdl/pspl_scan.sv */
// ----------------------------------------------------------------------------
// PAT section PMT PID lookup: section scanner
// Tracks the byte position, the declared length and the entry being
// assembled, and forms the result for the final byte of a section.
// ----------------------------------------------------------------------------
module pspl_scan import pspl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SERVICE_W-1:0] target_prog,
   input  logic                 consume,
   input  logic [7:0]           item_byte,
   input  logic                 item_last,
   output result_type           result
);

   logic [COUNT_W-1:0]   byte_count_ff,      byte_count_in;
   logic [LENGTH_W-1:0]  declared_length_ff, declared_length_in;
   logic [ENTRY_W-1:0]   entry_bytes_ff,     entry_bytes_in;
   logic                 match_seen_ff,      match_seen_in;
   logic [PID_W-1:0]     matched_pid_ff,     matched_pid_in;

   logic                 count_full;
   logic                 in_entries;
   logic                 in_body;
   logic [1:0]           phase;
   logic [COUNT_W:0]     entry_end;
   logic [COUNT_W:0]     length_total;
   logic [COUNT_W:0]     final_total;
   logic                 mismatch;

   // Position checks on the current byte.
   assign count_full   = &byte_count_ff;
   assign in_entries   = (byte_count_ff >= COUNT_W'(HEADER_BYTES)) && !count_full;
   assign phase        = byte_count_ff[1:0];
   assign entry_end    = {1'b0, byte_count_ff} + (COUNT_W+1)'(CRC_BYTES);
   assign length_total = {2'b00, declared_length_ff} + (COUNT_W+1)'(LEN_OVERHEAD);
   // An entry is compared only if it ends before the trailing CRC.
   assign in_body      = entry_end < length_total;

   // Next section state for the byte in the input register.
   always_comb begin
      declared_length_in = declared_length_ff;
      entry_bytes_in     = entry_bytes_ff;
      match_seen_in      = match_seen_ff;
      matched_pid_in     = matched_pid_ff;
      if (byte_count_ff == POS_LENGTH_HI) begin
         declared_length_in = {item_byte[3:0], declared_length_ff[7:0]};
      end else if (byte_count_ff == POS_LENGTH_LO) begin
         declared_length_in = {declared_length_ff[11:8], item_byte};
      end else if (in_entries) begin
         if (phase == PHASE_LAST) begin
            if (in_body && !match_seen_ff &&
                entry_bytes_ff[23:8] == target_prog) begin
               match_seen_in  = 1'b1;
               matched_pid_in = {entry_bytes_ff[4:0], item_byte};
            end
            entry_bytes_in = '0;
         end else begin
            entry_bytes_in = {entry_bytes_ff[15:0], item_byte};
         end
      end
      byte_count_in = count_full ? byte_count_ff : byte_count_ff + COUNT_W'(1);
   end

   // Result for a final byte, judged on the updated state.
   assign final_total = {2'b00, declared_length_in} + (COUNT_W+1)'(LEN_OVERHEAD);
   assign mismatch    = ({1'b0, byte_count_in} != final_total) ||
                        (byte_count_in > COUNT_W'(MAX_SECTION_BYTES));

   always_comb begin
      result.pmt_pid = '0;
      if (mismatch) begin
         result.status = STATUS_MISMATCH;
      end else if (match_seen_in) begin
         result.status  = STATUS_FOUND;
         result.pmt_pid = matched_pid_in;
      end else begin
         result.status = STATUS_NOT_FOUND;
      end
   end

   // Section state; a final byte clears it for the next section.
   always_ff @(posedge clock) begin
      if (reset || (consume && item_last)) begin
         byte_count_ff      <= '0;
         declared_length_ff <= '0;
         entry_bytes_ff     <= '0;
         match_seen_ff      <= 1'b0;
         matched_pid_ff     <= '0;
      end else if (consume) begin
         byte_count_ff      <= byte_count_in;
         declared_length_ff <= declared_length_in;
         entry_bytes_ff     <= entry_bytes_in;
         match_seen_ff      <= match_seen_in;
         matched_pid_ff     <= matched_pid_in;
      end
   end

endmodule

/* hdl/pspl_rsp_reg.sv */
// ----------------------------------------------------------------------------
// PAT section PMT PID lookup: result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module pspl_rsp_reg import pspl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  result_type       result,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [PID_W-1:0] rsp_pmt_pid
);

   logic       valid_ff;
   result_type result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_status  = result_ff.status;
   assign rsp_pmt_pid = result_ff.pmt_pid;

endmodule

/* hdl/pat_section_pmt_pid_lookup.sv */
// ----------------------------------------------------------------------------
// PAT section PMT PID lookup
// Scans a program association section byte by byte and reports the PMT PID
// of the configured program, or not found, or a section length mismatch.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  req_     | in        | section_byte[7:0], last_byte
//  rsp_     | out       | status[1:0], pmt_pid[12:0] (one item per section)
//  csr_     | in        | target_prog[15:0]
//
// One item per cycle is sustained while no stalled result holds a final
// byte; a byte waits in the input register, and a final byte's result is
// loaded into the result register as that byte is consumed. The scanner
// state updates once per byte. Reset is synchronous and clears all control and
// section state; target_prog resets to 0. A stalled result only holds back
// the final byte of the following section.
// ----------------------------------------------------------------------------
module pat_section_pmt_pid_lookup import pspl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_section_byte,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [PID_W-1:0]     rsp_pmt_pid,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SERVICE_W-1:0] csr_target_prog
);

   logic [SERVICE_W-1:0] target_prog_ff;
   logic                 item_valid;
   logic [7:0]           item_byte;
   logic                 item_last;
   logic                 consume;
   logic                 load;
   result_type           result;

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_prog_ff <= '0;
      end else if (csr_valid) begin
         target_prog_ff <= csr_target_prog;
      end
   end

   // A byte leaves the input register unless its result has nowhere to go.
   assign consume = item_valid && (!item_last || !rsp_valid || rsp_ready);
   assign load    = consume && item_last;

   pspl_in_reg u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_section_byte (req_section_byte),
      .req_last_byte    (req_last_byte),
      .consume          (consume),
      .item_valid       (item_valid),
      .item_byte        (item_byte),
      .item_last        (item_last)
   );

   pspl_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .target_prog (target_prog_ff),
      .consume     (consume),
      .item_byte   (item_byte),
      .item_last   (item_last),
      .result      (result)
   );

   pspl_rsp_reg u_rsp_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .result      (result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_pmt_pid (rsp_pmt_pid)
   );

`ifndef SYNTHESIS
   // A consumed final byte always produces a result item.
   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("final byte consumed without a result");

   // Only the defined status codes are reported.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_FOUND || rsp_status == STATUS_NOT_FOUND ||
                     rsp_status == STATUS_MISMATCH))
      else $error("undefined status code");

   // A PID is reported only when the program was found.
   a_pid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_FOUND) |-> rsp_pmt_pid == '0)
      else $error("nonzero PID without a match");

   // A final byte never overwrites a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !load)
      else $error("result overwritten while stalled");
`endif

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the PAT section PMT PID lookup
// Builds program association sections byte by byte, both well formed and
// broken, feeds them through the request channel and checks every lookup
// result against an in-bench prediction of the scanner. Covers the program
// number register, length mismatches, short sections, entries in the CRC
// area, first-match latching and backpressure.
// ----------------------------------------------------------------------------
module testbench;
   import pspl_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

   // Block ports, all inputs at known values from time zero.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_section_byte = '0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_status;
   logic [PID_W-1:0]     rsp_pmt_pid;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SERVICE_W-1:0] csr_target_prog = '0;

   // Idling controls shared by the sender, the receiver and the tests.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int bytes_accepted = 0;
   int failures = 0;

   // Section under construction and the lookups still to come.
   logic [7:0] section_bytes[$];
   result_type expected_lookups[$];

   // Scanner copy: register and per-section state.
   logic [SERVICE_W-1:0] want_target_prog = '0;
   logic [COUNT_W-1:0]   scan_count = '0;
   logic [LENGTH_W-1:0]  scan_length = '0;
   logic [ENTRY_W-1:0]   scan_entry = '0;
   logic                 scan_match = 1'b0;
   logic [PID_W-1:0]     scan_pid = '0;

   pat_section_pmt_pid_lookup u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_section_byte (req_section_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_pmt_pid      (rsp_pmt_pid),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_target_prog  (csr_target_prog)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #6000000;
      $display("Verification failed");
      $finish;
   end

   // Advance the scanner copy by one accepted byte and queue any lookup result.
   task automatic scan_section_byte(input logic [7:0] b, input logic last);
      int pos;
      logic [1:0] phase;
      logic in_body;
      result_type lookup;
      pos = int'(scan_count);
      if (pos == 1) begin
         scan_length = {b[3:0], scan_length[7:0]};
      end else if (pos == 2) begin
         scan_length[7:0] = b;
      end else if (pos >= HEADER_BYTES && scan_count != COUNT_SAT) begin
         phase = 2'(pos - HEADER_BYTES);
         // An entry counts only if it ends before the trailing CRC.
         in_body = (pos + CRC_BYTES) < (int'(scan_length) + LEN_OVERHEAD);
         if (phase == PHASE_LAST) begin
            if (in_body && !scan_match && scan_entry[23:8] == want_target_prog) begin
               scan_match = 1'b1;
               scan_pid = {scan_entry[4:0], b};
            end
            scan_entry = '0;
         end else begin
            scan_entry = {scan_entry[15:0], b};
         end
      end
      if (scan_count != COUNT_SAT) begin
         scan_count = scan_count + 1'b1;
      end
      if (last) begin
         lookup.pmt_pid = '0;
         if (int'(scan_count) != int'(scan_length) + LEN_OVERHEAD ||
             scan_count > MAX_SECTION_BYTES) begin
            lookup.status = STATUS_MISMATCH;
         end else if (scan_match) begin
            lookup.status = STATUS_FOUND;
            lookup.pmt_pid = scan_pid;
         end else begin
            lookup.status = STATUS_NOT_FOUND;
         end
         expected_lookups.push_back(lookup);
         scan_count = '0;
         scan_length = '0;
         scan_entry = '0;
         scan_match = 1'b0;
         scan_pid = '0;
      end
   endtask

   // Offer one item and hold it until accepted, then idle at random.
   task automatic send_byte(input logic [7:0] b, input logic last);
      req_valid <= 1'b1;
      req_section_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      scan_section_byte(b, last);
      bytes_accepted++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Build a section: header with the given length field, then 4-byte entries
   // (program number, reserved bits, PID) and a 4-byte CRC. Slot match_slot
   // carries the sought program number with match_pid; slot repeat_slot carries
   // it with a random PID. With crc_entries set the CRC bytes are laid out as
   // an entry.
   task automatic build_section(input int len_field, input int total, input int match_slot,
                                input logic [PID_W-1:0] match_pid, input int repeat_slot,
                                input bit crc_entries);
      int i;
      int slot;
      logic [15:0] prog;
      logic [PID_W-1:0] pid;
      logic [7:0] b;
      prog = '0;
      pid = '0;
      section_bytes.delete();
      for (i = 0; i < total; i++) begin
         if (i == 0 || (i > 2 && i < HEADER_BYTES)) begin
            b = 8'($urandom);
         end else if (i == 1) begin
            b = {4'($urandom), 4'(len_field >> 8)};
         end else if (i == 2) begin
            b = 8'(len_field);
         end else if (!crc_entries && total >= 12 && i >= total - CRC_BYTES) begin
            b = 8'($urandom);
         end else begin
            slot = (i - HEADER_BYTES) / 4;
            if (((i - HEADER_BYTES) % 4) == 0) begin
               prog = 16'($urandom);
               pid = PID_W'($urandom);
               if (slot == match_slot) begin
                  prog = want_target_prog;
                  pid = match_pid;
               end else if (slot == repeat_slot) begin
                  prog = want_target_prog;
               end
            end
            case ((i - HEADER_BYTES) % 4)
               0: begin
                  b = prog[15:8];
               end
               1: begin
                  b = prog[7:0];
               end
               2: begin
                  b = {3'($urandom), pid[12:8]};
               end
               default: begin
                  b = pid[7:0];
               end
            endcase
         end
         section_bytes.push_back(b);
      end
   endtask

   task automatic send_section();
      int i;
      for (i = 0; i < section_bytes.size(); i++) begin
         send_byte(section_bytes[i], i == section_bytes.size() - 1);
      end
   endtask

   // Well-formed section with n entries.
   task automatic send_entries(input int n, input int match_slot, input logic [PID_W-1:0] pid,
                               input int repeat_slot);
      build_section(9 + 4 * n, 12 + 4 * n, match_slot, pid, repeat_slot, 1'b0);
      send_section();
   endtask

   // Stop offering, wait for every lookup, then let the pipeline settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_target_prog(input logic [SERVICE_W-1:0] id);
      wait_drained();
      csr_valid <= 1'b1;
      csr_target_prog <= id;
      do @(posedge clock); while (!csr_ready);
      want_target_prog = id;
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_request > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_request - 1;
         hold_request = 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each accepted result with the oldest expected lookup.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lookups.size() == 0) begin
            $display("%0t: unexpected result status %0d pid %0d", $time, rsp_status,
                     rsp_pmt_pid);
            failures++;
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               failures++;
            end
            if (rsp_pmt_pid !== want.pmt_pid) begin
               $display("%0t: pmt_pid expected %0d actual %0d", $time, want.pmt_pid,
                        rsp_pmt_pid);
               failures++;
            end
         end
      end
   end

   // Program number 0 out of reset, then the all-ones number.
   task automatic test_target_prog_extremes();
      send_entries(2, 1, 13'h0abc, -1);
      send_entries(0, -1, '0, -1);
      set_target_prog(16'hffff);
      send_entries(3, 0, 13'h1fff, -1);
      send_entries(2, -1, '0, -1);
   endtask

   // Found with PID zero and alternating-bit PIDs, and only the first match is latched.
   task automatic test_entry_matching();
      set_target_prog(16'h1234);
      send_entries(1, 0, 13'h0000, -1);
      send_entries(4, 3, 13'h1555, -1);
      send_entries(4, 1, 13'h0aaa, 2);
      send_entries(5, 4, 13'h0001, -1);
   endtask

   // A matching entry laid over the CRC bytes must not be taken.
   task automatic test_crc_region();
      build_section(9, 12, 0, 13'h0123, -1, 1'b1);
      send_section();
      build_section(13, 16, 1, 13'h0456, -1, 1'b1);
      send_section();
      // Length one short of the entries: the last entry reaches into the CRC.
      build_section(12, 15, 1, 13'h0789, -1, 1'b1);
      send_section();
   endtask

   // Byte totals that disagree with the length field, each with a matching entry.
   task automatic test_length_mismatch();
      build_section(13, 17, 0, 13'h0321, -1, 1'b0);
      send_section();
      build_section(13, 15, 0, 13'h0321, -1, 1'b0);
      send_section();
      build_section(4095, 20, 0, 13'h0055, -1, 1'b0);
      send_section();
   endtask

   // Sections that end inside the header.
   task automatic test_short_sections();
      int total;
      for (total = 1; total <= 8; total++) begin
         build_section(0, total, -1, '0, -1, 1'b0);
         send_section();
      end
      build_section(5, 8, -1, '0, -1, 1'b0);
      send_section();
   endtask

   // Receiver holds off long enough for the block to stall its input.
   task automatic test_result_holdoff();
      int i;
      set_target_prog(16'h0100);
      hold_request = 300;
      for (i = 0; i < 15; i++) begin
         send_entries(i % 3, (i % 2) ? 0 : -1, PID_W'($urandom), -1);
      end
      wait_drained();
   endtask

   // Mostly well-formed sections with random content, some broken ones.
   task automatic test_random_sections(input int send_pct, input int recv_pct,
                                       input int byte_budget);
      int kind;
      int n;
      int len;
      int total;
      int match_slot;
      int repeat_slot;
      int stop_at;
      case ($urandom_range(3))
         0: begin
            set_target_prog('0);
         end
         1: begin
            set_target_prog('1);
         end
         default: begin
            set_target_prog(16'($urandom));
         end
      endcase
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      stop_at = bytes_accepted + byte_budget;
      while (bytes_accepted < stop_at) begin
         kind = $urandom_range(99);
         n = ($urandom_range(9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
         len = 9 + 4 * n;
         total = len + 3;
         match_slot = $urandom_range(1) ? $urandom_range(0, n) : -1;
         repeat_slot = $urandom_range(3) == 0 ? $urandom_range(0, n) : -1;
         if (kind >= 70 && kind < 82) begin
            // Wrong byte total.
            total = total + ($urandom_range(1) ? $urandom_range(1, 3) : -$urandom_range(1, 3));
         end else if (kind >= 82 && kind < 90) begin
            // Length not a whole number of entries.
            len = len + $urandom_range(1, 3);
            total = len + 3;
         end else if (kind >= 90) begin
            // Noise.
            len = $urandom_range(4095);
            total = $urandom_range(1, 24);
         end
         build_section(len, total, match_slot, PID_W'($urandom), repeat_slot,
                       $urandom_range(9) == 0);
         send_section();
      end
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_target_prog_extremes();
      test_entry_matching();
      test_crc_region();
      test_length_mismatch();
      test_short_sections();
      test_result_holdoff();
      test_random_sections(0, 0, 150);
      test_random_sections(59, 0, 150);
      test_random_sections(0, 59, 150);
      test_random_sections(25, 25, 150);
      wait_drained();
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
